@@ rtl/core/bwcs_pkg.sv @@
// Package for the burst waveform channel sequencer core.
// Holds table sizes, operation and result codes, register indexes and phase type.
// No dependencies.
package bwcs_pkg;

    localparam int ENTRIES     = 32;
    localparam int ENTRY_IDX_W = $clog2(ENTRIES);
    localparam int ENTRY_CNT_W = ENTRY_IDX_W + 1;

    localparam logic [15:0] TICK_PERIOD = 16'd100;
    localparam logic [7:0]  LEVEL_MAX   = 8'hff;
    localparam int          GAIN_FRAC_W = 8;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_SEG   = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_NONE        = 3'd0,
        KIND_RELOAD      = 3'd1,
        KIND_BURST_START = 3'd2,
        KIND_CHANNEL     = 3'd3,
        KIND_ACTIVE_TICK = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        TSEL_FLAT = 2'd0,
        TSEL_RISE = 2'd1,
        TSEL_FALL = 2'd2
    } tsel_t;

    typedef enum logic [1:0] {
        PH_RISE       = 2'd0,
        PH_SHORT_FLAT = 2'd1,
        PH_FALL       = 2'd2,
        PH_LONG_FLAT  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_RISE_PERIOD       = 3'd0,
        REG_SHORT_FLAT_PERIOD = 3'd1,
        REG_FALL_PERIOD       = 3'd2,
        REG_LONG_FLAT_PERIOD  = 3'd3,
        REG_WAVES_PER_BURST   = 3'd4,
        REG_PAUSE_TICKS       = 3'd5,
        REG_ACTIVE_ENTRIES    = 3'd6,
        REG_BASE_GAIN         = 3'd7
    } reg_idx_t;

endpackage

@@ rtl/core/burst_waveform_channel_sequencer_core.sv @@
// Burst waveform channel sequencer core: top level.
// Depends on bwcs_pkg (codes, table size, phase type).
//
// Each input transaction is processed combinationally: the operation is decoded against
// the sequencer state and the channel table, and exactly one result transaction is
// written to the output register on the clock edge that accepts it. A new input is
// accepted every cycle while the output register is empty or being taken at the same
// edge, so the sustained rate is one transaction per cycle; the output register is the
// only thing that can hold the input side back. The channel table has 32 slots kept in
// flip-flops, written by load transactions and read at the current entry; slots never
// loaded hold no defined contents. Configuration writes are taken at any time (cfg_ready
// is always high) and should only be issued while the core is idle.
module burst_waveform_channel_sequencer_core
    import bwcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [4:0]  entry_index,
    input  logic [15:0] entry_channel_word,
    input  logic [7:0]  entry_level,
    input  logic [7:0]  entry_bursts,
    input  logic [1:0]  intensity_select,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [15:0] timer_period,
    output logic [1:0]  table_select,
    output logic [1:0]  table_intensity,
    output logic [15:0] channel_word,
    output logic [7:0]  drive_level,
    output logic        drive_update,
    output logic        running
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [15:0]            rise_period_reg;
    logic [15:0]            short_flat_period_reg;
    logic [15:0]            fall_period_reg;
    logic [15:0]            long_flat_period_reg;
    logic [15:0]            waves_per_burst_reg;
    logic [15:0]            pause_ticks_reg;
    logic [ENTRY_CNT_W-1:0] active_entries_reg;
    logic [15:0]            base_gain_reg;
    logic [5:0]             cfg_active_entries;

    assign cfg_ready          = 1'b1;
    assign cfg_active_entries = cfg_data[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_period_reg       <= '0;
            short_flat_period_reg <= '0;
            fall_period_reg       <= '0;
            long_flat_period_reg  <= '0;
            waves_per_burst_reg   <= '0;
            pause_ticks_reg       <= '0;
            active_entries_reg    <= '0;
            base_gain_reg         <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_RISE_PERIOD:       rise_period_reg       <= cfg_data;
                REG_SHORT_FLAT_PERIOD: short_flat_period_reg <= cfg_data;
                REG_FALL_PERIOD:       fall_period_reg       <= cfg_data;
                REG_LONG_FLAT_PERIOD:  long_flat_period_reg  <= cfg_data;
                REG_WAVES_PER_BURST:   waves_per_burst_reg   <= cfg_data;
                REG_PAUSE_TICKS:       pause_ticks_reg       <= cfg_data;
                REG_ACTIVE_ENTRIES:    active_entries_reg    <= cfg_active_entries[ENTRY_CNT_W-1:0];
                REG_BASE_GAIN:         base_gain_reg         <= cfg_data;
                default:               ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: take a new transaction whenever the result slot frees up
    // ---------------------------------------------------------------------
    logic in_fire;

    assign in_ready = !out_valid || out_ready;
    assign in_fire  = in_valid && in_ready;

    // ---------------------------------------------------------------------
    // Channel table (no reset, contents valid once loaded)
    // ---------------------------------------------------------------------
    logic [15:0] channel_words_reg      [ENTRIES];
    logic [7:0]  entry_levels_reg       [ENTRIES];
    logic [7:0]  entry_burst_counts_reg [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (in_fire && (op_t'(operation) == OP_LOAD))
        begin
            channel_words_reg[entry_index]      <= entry_channel_word;
            entry_levels_reg[entry_index]       <= entry_level;
            entry_burst_counts_reg[entry_index] <= entry_bursts;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------
    logic                   armed_reg,         armed_next;
    phase_t                 phase_reg,         phase_next;
    logic [15:0]            waves_left_reg,    waves_left_next;
    logic [15:0]            pause_count_reg,   pause_count_next;
    logic [7:0]             bursts_done_reg,   bursts_done_next;
    logic [ENTRY_IDX_W-1:0] current_entry_reg, current_entry_next;
    logic [1:0]             shape_set_reg,     shape_set_next;

    // Current entry read and entry pointer advance
    logic [15:0]            cur_word;
    logic [7:0]             cur_level;
    logic [7:0]             cur_need;
    logic [ENTRY_CNT_W-1:0] entry_limit;
    logic [ENTRY_CNT_W-1:0] entry_plus_one;
    logic                   entry_wrap;
    logic [ENTRY_IDX_W-1:0] entry_advanced;

    assign cur_word  = channel_words_reg[current_entry_reg];
    assign cur_level = entry_levels_reg[current_entry_reg];
    assign cur_need  = entry_burst_counts_reg[current_entry_reg];

    // active_entries saturates at the table size
    assign entry_limit    = (active_entries_reg > ENTRY_CNT_W'(ENTRIES))
                            ? ENTRY_CNT_W'(ENTRIES) : active_entries_reg;
    assign entry_plus_one = {1'b0, current_entry_reg} + ENTRY_CNT_W'(1);
    assign entry_wrap     = (entry_plus_one >= entry_limit);
    assign entry_advanced = entry_wrap ? '0 : entry_plus_one[ENTRY_IDX_W-1:0];

    // Level scaling: 8 x 16 product, drop the fraction, clamp
    logic [23:0] level_product;
    logic [15:0] level_scaled;
    logic [7:0]  level_sat;

    assign level_product = 24'(cur_level) * 24'(base_gain_reg);
    assign level_scaled  = level_product[23:GAIN_FRAC_W];
    assign level_sat     = (level_scaled[15:8] != 8'd0) ? LEVEL_MAX : level_scaled[7:0];

    // Segment reload fields by phase
    logic [15:0] seg_period;
    tsel_t       seg_tsel;
    logic [1:0]  seg_tint;

    always_comb
    begin
        seg_period = rise_period_reg;
        seg_tsel   = TSEL_FLAT;
        seg_tint   = 2'd0;
        case (phase_reg)
            PH_RISE:
            begin
                seg_period = rise_period_reg;
                seg_tsel   = TSEL_RISE;
                seg_tint   = shape_set_reg;
            end
            PH_SHORT_FLAT: seg_period = short_flat_period_reg;
            PH_FALL:
            begin
                seg_period = fall_period_reg;
                seg_tsel   = TSEL_FALL;
                seg_tint   = shape_set_reg;
            end
            PH_LONG_FLAT:  seg_period = long_flat_period_reg;
            default:       seg_period = rise_period_reg;
        endcase
    end

    // Result next values
    kind_t       kind_next;
    logic [15:0] period_next;
    tsel_t       tsel_next;
    logic [1:0]  tint_next;
    logic [15:0] word_next;
    logic [7:0]  level_next;
    logic        update_next;
    logic [7:0]  bursts_plus_one;

    assign bursts_plus_one = bursts_done_reg + 8'd1;

    always_comb
    begin
        armed_next         = armed_reg;
        phase_next         = phase_reg;
        waves_left_next    = waves_left_reg;
        pause_count_next   = pause_count_reg;
        bursts_done_next   = bursts_done_reg;
        current_entry_next = current_entry_reg;
        shape_set_next     = shape_set_reg;
        kind_next          = KIND_NONE;
        period_next        = '0;
        tsel_next          = TSEL_FLAT;
        tint_next          = '0;
        word_next          = '0;
        level_next         = '0;
        update_next        = 1'b0;

        case (op_t'(operation))
            OP_LOAD: ;
            OP_START:
            begin
                armed_next         = 1'b1;
                shape_set_next     = intensity_select;
                phase_next         = PH_RISE;
                waves_left_next    = '0;
                pause_count_next   = '0;
                bursts_done_next   = '0;
                current_entry_next = '0;
            end
            OP_SEG:
            begin
                if (!armed_reg)
                begin
                    // not armed: nothing moves
                end
                else if (waves_left_reg == 16'd0)
                begin
                    if (pause_count_reg < pause_ticks_reg)
                    begin
                        pause_count_next = pause_count_reg + 16'd1;
                    end
                    else
                    begin
                        // pause over: start the next burst
                        pause_count_next = '0;
                        waves_left_next  = waves_per_burst_reg;
                        bursts_done_next = bursts_plus_one;
                        kind_next        = KIND_BURST_START;
                        period_next      = rise_period_reg;
                        if (bursts_plus_one >= cur_need)
                        begin
                            bursts_done_next   = '0;
                            current_entry_next = entry_advanced;
                            if (entry_wrap)
                            begin
                                armed_next = 1'b0;
                            end
                        end
                    end
                end
                else
                begin
                    kind_next   = KIND_RELOAD;
                    period_next = seg_period;
                    tsel_next   = seg_tsel;
                    tint_next   = seg_tint;
                    if (phase_reg == PH_LONG_FLAT)
                    begin
                        phase_next      = PH_RISE;
                        waves_left_next = waves_left_reg - 16'd1;
                    end
                    else
                    begin
                        phase_next = phase_t'(phase_reg + 2'd1);
                    end
                end
            end
            OP_TICK:
            begin
                if (waves_left_reg != 16'd0)
                begin
                    kind_next   = KIND_ACTIVE_TICK;
                    period_next = TICK_PERIOD;
                end
                else
                begin
                    kind_next = KIND_CHANNEL;
                    if (cur_need == 8'd0)
                    begin
                        // empty entry: skip it, armed is left alone
                        current_entry_next = entry_advanced;
                    end
                    else
                    begin
                        word_next   = cur_word;
                        level_next  = level_sat;
                        update_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg         <= 1'b0;
            phase_reg         <= PH_RISE;
            waves_left_reg    <= '0;
            pause_count_reg   <= '0;
            bursts_done_reg   <= '0;
            current_entry_reg <= '0;
            shape_set_reg     <= '0;
        end
        else if (in_fire)
        begin
            armed_reg         <= armed_next;
            phase_reg         <= phase_next;
            waves_left_reg    <= waves_left_next;
            pause_count_reg   <= pause_count_next;
            bursts_done_reg   <= bursts_done_next;
            current_entry_reg <= current_entry_next;
            shape_set_reg     <= shape_set_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_kind     <= kind_next;
            timer_period    <= period_next;
            table_select    <= tsel_next;
            table_intensity <= tint_next;
            channel_word    <= word_next;
            drive_level     <= level_next;
            drive_update    <= update_next;
            running         <= armed_next;
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // A segment reload only happens while armed, and armed is kept on that path
    a_reload_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_RELOAD) |-> running)
        else $error("segment reload reported while not running");

    // Drive level updates come only with a channel select
    a_update_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_update |-> (result_kind == KIND_CHANNEL))
        else $error("drive update outside a channel select");

    // An accepted start always yields a running result on the next edge
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (operation == OP_START)
        |=> out_valid && running && (result_kind == KIND_NONE))
        else $error("start transaction did not arm the sequencer");

    // Burst-active ticks carry the fixed tick period
    a_tick_period: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_ACTIVE_TICK) |-> (timer_period == TICK_PERIOD))
        else $error("active tick with wrong period");

endmodule
